// File: hw/rtl/sft_pkg.sv
// Package for the symbol frequency table.
// Holds the default widths and command codes shared by the interfaces, top level and bench.
package sft_pkg;

    localparam int SYMBOL_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int COMMAND_BITS    = 2;

    typedef enum logic [COMMAND_BITS-1:0] {
        CMD_COUNT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

endpackage

// File: hw/rtl/sft_if.sv
// Request and result channel interfaces of the symbol frequency table.
// Depends on sft_pkg for default widths.
interface sft_in_if #(
    parameter int SYMBOL_BITS = sft_pkg::SYMBOL_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic [sft_pkg::COMMAND_BITS-1:0] command;
    logic [SYMBOL_BITS-1:0]           symbol;
    logic [SYMBOL_BITS-1:0]           slot_index;
    logic                             last_symbol;

    modport source (output valid, command, symbol, slot_index, last_symbol, input ready);
    modport sink   (input valid, command, symbol, slot_index, last_symbol, output ready);
endinterface

interface sft_out_if #(
    parameter int SYMBOL_BITS = sft_pkg::SYMBOL_BITS_DEF,
    parameter int COUNT_BITS  = sft_pkg::COUNT_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] slot;
    logic [SYMBOL_BITS-1:0] symbol_out;
    logic [COUNT_BITS-1:0]  frequency;
    logic                   is_new;
    logic                   entry_valid;
    logic [SYMBOL_BITS:0]   distinct_count;
    logic                   message_done;

    modport source (output valid, slot, symbol_out, frequency, is_new, entry_valid,
                    distinct_count, message_done, input ready);
    modport sink   (input valid, slot, symbol_out, frequency, is_new, entry_valid,
                    distinct_count, message_done, output ready);
endinterface

// File: hw/rtl/symbol_frequency_table.sv
// Symbol frequency table, slots in order of first appearance.
// Depends on sft_pkg and the channel interfaces in sft_if.sv.
//
//  port    dir  word carries
//  ------  ---  ---------------------------------------------------------
//  i_in    in   command, symbol, slot_index, last_symbol
//  o_out   out  slot, symbol_out, frequency, is_new, entry_valid,
//               distinct_count, message_done
//
// Count of a known symbol: slot map read, then slot read (S_MAP), then write back (S_FIN).
// New symbol, read, clear, unused code: straight from S_IDLE to S_FIN, skipping S_MAP.
// One word in flight; the next is taken while a result still waits on o_out.
// Reset clears seen flags and slots-used count; memories hold no reset value.
// A stalled o_out holds the finished word in S_FIN until the word waiting on o_out is taken.
module symbol_frequency_table #(
    parameter int SYMBOL_BITS = sft_pkg::SYMBOL_BITS_DEF,
    parameter int COUNT_BITS  = sft_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sft_in_if.sink     i_in,
    sft_out_if.source  o_out
);
    import sft_pkg::*;

    localparam int NSYM      = 1 << SYMBOL_BITS;
    localparam int ENT_BITS  = SYMBOL_BITS + COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAP  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [COMMAND_BITS-1:0] r_cmd;
    logic [SYMBOL_BITS-1:0]  r_sym;
    logic [SYMBOL_BITS-1:0]  r_idx;
    logic                    r_last;
    logic                    r_hit;
    logic                    r_idx_ok;

    logic [NSYM-1:0]         r_seen;
    logic [SYMBOL_BITS:0]    r_used;

    logic [SYMBOL_BITS-1:0]  mem_map [NSYM];
    logic [ENT_BITS-1:0]     mem_ent [NSYM];
    logic [SYMBOL_BITS-1:0]  r_map_q;
    logic [ENT_BITS-1:0]     r_ent_q;

    logic                    in_acc;
    logic                    fin_go;
    logic                    ent_re;
    logic [SYMBOL_BITS-1:0]  ent_ra;
    logic                    wr_new;
    logic                    wr_inc;
    logic [SYMBOL_BITS-1:0]  new_slot;
    logic [COUNT_BITS-1:0]   old_cnt;
    logic [COUNT_BITS-1:0]   inc_cnt;

    logic                    r_out_valid;
    logic [SYMBOL_BITS-1:0]  r_o_slot,  n_o_slot;
    logic [SYMBOL_BITS-1:0]  r_o_sym,   n_o_sym;
    logic [COUNT_BITS-1:0]   r_o_freq,  n_o_freq;
    logic                    r_o_new,   n_o_new;
    logic                    r_o_valid, n_o_valid;
    logic [SYMBOL_BITS:0]    r_o_dist,  n_o_dist;
    logic                    r_o_done,  n_o_done;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign fin_go     = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    assign ent_re   = in_acc || (r_state == S_MAP);
    assign ent_ra   = (r_state == S_MAP) ? r_map_q : i_in.slot_index;
    assign new_slot = r_used[SYMBOL_BITS-1:0];
    assign old_cnt  = r_ent_q[COUNT_BITS-1:0];
    assign inc_cnt  = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
    assign wr_new   = fin_go && (r_cmd == CMD_COUNT) && !r_hit;
    assign wr_inc   = fin_go && (r_cmd == CMD_COUNT) && r_hit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if ((i_in.command == CMD_COUNT) && r_seen[i_in.symbol]) begin
                        n_state = S_MAP;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MAP:   n_state = S_FIN;
            S_FIN:   if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_o_slot  = '0;
        n_o_sym   = '0;
        n_o_freq  = '0;
        n_o_new   = 1'b0;
        n_o_valid = 1'b0;
        n_o_dist  = r_used;
        n_o_done  = 1'b0;
        case (r_cmd)
            CMD_COUNT: begin
                n_o_valid = 1'b1;
                n_o_done  = r_last;
                if (r_hit) begin
                    n_o_slot = r_map_q;
                    n_o_sym  = r_ent_q[ENT_BITS-1:COUNT_BITS];
                    n_o_freq = inc_cnt;
                end else begin
                    n_o_slot = new_slot;
                    n_o_sym  = r_sym;
                    n_o_freq = COUNT_BITS'(1);
                    n_o_new  = 1'b1;
                    n_o_dist = r_used + 1'b1;
                end
            end
            CMD_READ: begin
                n_o_slot = r_idx;
                if (r_idx_ok) begin
                    n_o_sym   = r_ent_q[ENT_BITS-1:COUNT_BITS];
                    n_o_freq  = old_cnt;
                    n_o_valid = 1'b1;
                end
            end
            CMD_CLEAR: n_o_dist = '0;
            default:   n_o_dist = r_used;
        endcase
    end

    // slot map: symbol -> slot
    always_ff @(posedge i_clk) begin
        if (wr_new) mem_map[r_sym] <= new_slot;
        if (in_acc) r_map_q <= mem_map[i_in.symbol];
    end

    // slot table: {symbol, count}
    always_ff @(posedge i_clk) begin
        if (wr_new) begin
            mem_ent[new_slot] <= {r_sym, COUNT_BITS'(1)};
        end else if (wr_inc) begin
            mem_ent[r_map_q] <= {r_ent_q[ENT_BITS-1:COUNT_BITS], inc_cnt};
        end
        if (ent_re) r_ent_q <= mem_ent[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_in.command;
            r_sym    <= i_in.symbol;
            r_idx    <= i_in.slot_index;
            r_last   <= i_in.last_symbol;
            r_hit    <= r_seen[i_in.symbol];
            r_idx_ok <= ({1'b0, i_in.slot_index} < r_used);
        end
        if (fin_go) begin
            r_o_slot  <= n_o_slot;
            r_o_sym   <= n_o_sym;
            r_o_freq  <= n_o_freq;
            r_o_new   <= n_o_new;
            r_o_valid <= n_o_valid;
            r_o_dist  <= n_o_dist;
            r_o_done  <= n_o_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go && (r_cmd == CMD_CLEAR)) begin
                r_seen <= '0;
                r_used <= '0;
            end else if (wr_new) begin
                r_seen[r_sym] <= 1'b1;
                r_used        <= r_used + 1'b1;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.slot           = r_o_slot;
    assign o_out.symbol_out     = r_o_sym;
    assign o_out.frequency      = r_o_freq;
    assign o_out.is_new         = r_o_new;
    assign o_out.entry_valid    = r_o_valid;
    assign o_out.distinct_count = r_o_dist;
    assign o_out.message_done   = r_o_done;

    a_used_matches_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_seen) == 32'(r_used))
        else $error("slots used out of step with seen flags");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("second word taken while one is in flight");

    a_new_slot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_new) |->
            (o_out.frequency == COUNT_BITS'(1)) && o_out.entry_valid
            && (o_out.distinct_count == {1'b0, o_out.slot} + 1'b1))
        else $error("new slot word inconsistent");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for symbol_frequency_table: drives request words, predicts
// each result word from a local copy of the table and checks them in order.
// Depends on sft_pkg, the channel interfaces in sft_if.sv and the top level.
module tb_top;

    import sft_pkg::*;

    localparam int SB         = SYMBOL_BITS_DEF;
    localparam int CB         = COUNT_BITS_DEF;
    localparam int NSYM       = 1 << SB;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int HOLD_AT    = 400;
    localparam int TAIL       = 10;
    localparam int BURST_LEN  = 40;

    typedef struct packed {
        t_cmd            command;
        logic [SB-1:0]   symbol;
        logic [SB-1:0]   slot_index;
        logic            last_symbol;
        logic            drain;
        logic            quick;
    } t_req;

    typedef struct packed {
        logic [SB-1:0]   slot;
        logic [SB-1:0]   symbol_out;
        logic [CB-1:0]   frequency;
        logic            is_new;
        logic            entry_valid;
        logic [SB:0]     distinct_count;
        logic            message_done;
    } t_freq_word;

    logic i_clk;
    logic i_rst_n;

    sft_in_if  #(.SYMBOL_BITS(SB))                 req_bus ();
    sft_out_if #(.SYMBOL_BITS(SB), .COUNT_BITS(CB)) res_bus ();

    symbol_frequency_table #(
        .SYMBOL_BITS (SB),
        .COUNT_BITS  (CB)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (res_bus)
    );

    // local copy of the table
    logic          seen_sym  [NSYM];
    logic [SB-1:0] slot_map  [NSYM];
    logic [SB-1:0] slot_sym  [NSYM];
    logic [CB-1:0] slot_freq [NSYM];
    logic [SB:0]   used_slots;

    t_req       feed_q [$];
    t_freq_word expected_words [$];
    t_req       cur_req      = '0;
    logic       in_fire      = 1'b0;
    logic       out_fire     = 1'b0;
    logic       quick_now    = 1'b0;
    logic       hold_done    = 1'b0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned results_taken = 0;
    int unsigned idle_cycles = 0;
    int unsigned fail_count  = 0;
    int unsigned total_words = 0;
    logic [31:0] cyc         = '0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cyc[8:7] == 2'b11) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_freq_word next_freq_word(t_cmd cmd, logic [SB-1:0] sym,
                                                  logic [SB-1:0] idx, logic last);
        t_freq_word w;
        logic [SB-1:0] s;
        w = '0;
        case (cmd)
            CMD_COUNT: begin
                if (seen_sym[sym]) begin
                    s = slot_map[sym];
                    if (slot_freq[s] != {CB{1'b1}}) slot_freq[s] = slot_freq[s] + 1'b1;
                end else begin
                    s = used_slots[SB-1:0];
                    seen_sym[sym] = 1'b1;
                    slot_map[sym] = s;
                    slot_sym[s]   = sym;
                    slot_freq[s]  = CB'(1);
                    if (used_slots < NSYM) used_slots = used_slots + 1'b1;
                    w.is_new = 1'b1;
                end
                w.slot           = s;
                w.symbol_out     = slot_sym[s];
                w.frequency      = slot_freq[s];
                w.entry_valid    = 1'b1;
                w.distinct_count = used_slots;
                w.message_done   = last;
            end
            CMD_READ: begin
                w.slot           = idx;
                w.distinct_count = used_slots;
                if ({1'b0, idx} < used_slots) begin
                    w.symbol_out  = slot_sym[idx];
                    w.frequency   = slot_freq[idx];
                    w.entry_valid = 1'b1;
                end
            end
            CMD_CLEAR: begin
                foreach (seen_sym[k]) seen_sym[k] = 1'b0;
                used_slots = '0;
            end
            default: begin
                w.distinct_count = used_slots;
            end
        endcase
        return w;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic add_req(t_cmd c, int unsigned sym, int unsigned idx, int unsigned last,
                           bit drain = 1'b0, bit quick = 1'b0);
        t_req r;
        r.command     = c;
        r.symbol      = SB'(sym);
        r.slot_index  = SB'(idx);
        r.last_symbol = last[0];
        r.drain       = drain;
        r.quick       = quick;
        feed_q.push_back(r);
    endtask

    task automatic queue_message(int unsigned len, int unsigned alpha);
        int unsigned base;
        int unsigned r;
        base = $urandom_range(0, NSYM - 1);
        add_req(CMD_CLEAR, $urandom, $urandom, $urandom);
        for (int unsigned k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 78)
                add_req(CMD_COUNT, (base + $urandom_range(0, alpha - 1)) % NSYM, $urandom,
                        k == len - 1);
            else if (r < 92)
                add_req(CMD_READ, $urandom, $urandom_range(0, alpha), $urandom);
            else if (r < 95)
                add_req(CMD_READ, $urandom, $urandom, $urandom);
            else if (r < 98)
                add_req(CMD_SPARE, $urandom, $urandom, $urandom);
            else
                add_req(CMD_CLEAR, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic queue_full_set();
        int unsigned perm [NSYM];
        int unsigned j;
        int unsigned t;
        foreach (perm[k]) perm[k] = k;
        for (int k = NSYM - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            t       = perm[k];
            perm[k] = perm[j];
            perm[j] = t;
        end
        add_req(CMD_CLEAR, $urandom, $urandom, $urandom);
        foreach (perm[k]) add_req(CMD_COUNT, perm[k], $urandom, k == NSYM - 1);
        add_req(CMD_READ, $urandom, NSYM - 1, $urandom);
        add_req(CMD_READ, $urandom, 0, $urandom);
        add_req(CMD_COUNT, perm[$urandom_range(0, NSYM - 1)], $urandom, 1);
        add_req(CMD_SPARE, $urandom, $urandom, $urandom);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request side: one word held until taken, then a random gap (none after quick words)
    always @(negedge i_clk) begin
        t_req nxt;
        logic v;
        if (i_rst_n) begin
            nxt = cur_req;
            v   = req_bus.valid;
            if (in_fire) v = 1'b0;
            if (!v) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (feed_q.size() != 0 &&
                             !(feed_q[0].drain && expected_words.size() != 0)) begin
                    nxt = feed_q.pop_front();
                    v   = 1'b1;
                    gap_left  <= nxt.quick ? 0 : pick_gap();
                    quick_now <= nxt.quick;
                end
            end
            cur_req             <= nxt;
            req_bus.valid       <= v;
            req_bus.command     <= nxt.command;
            req_bus.symbol      <= nxt.symbol;
            req_bus.slot_index  <= nxt.slot_index;
            req_bus.last_symbol <= nxt.last_symbol;
        end
    end

    // result side: random stalls after each word (none after quick words), one long hold-off
    always @(negedge i_clk) begin
        int unsigned s;
        s = stall_left;
        if (out_fire && !quick_now) s = pick_gap();
        if (!hold_done && results_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            s = HOLD_LEN;
        end
        if (s != 0) begin
            res_bus.ready <= 1'b0;
            stall_left    <= s - 1;
        end else begin
            res_bus.ready <= 1'b1;
            stall_left    <= 0;
        end
    end

    always @(posedge i_clk) begin
        t_freq_word got;
        t_freq_word want;
        if (i_rst_n) begin
            cyc      <= cyc + 1;
            in_fire  <= req_bus.valid && req_bus.ready;
            out_fire <= res_bus.valid && res_bus.ready;
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (res_bus.valid && res_bus.ready) begin
                results_taken <= results_taken + 1;
                got.slot           = res_bus.slot;
                got.symbol_out     = res_bus.symbol_out;
                got.frequency      = res_bus.frequency;
                got.is_new         = res_bus.is_new;
                got.entry_valid    = res_bus.entry_valid;
                got.distinct_count = res_bus.distinct_count;
                got.message_done   = res_bus.message_done;
                if (expected_words.size() == 0) begin
                    $error("result word with none expected");
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("slot", want.slot, got.slot);
                    check_field("symbol_out", want.symbol_out, got.symbol_out);
                    check_field("frequency", want.frequency, got.frequency);
                    check_field("is_new", want.is_new, got.is_new);
                    check_field("entry_valid", want.entry_valid, got.entry_valid);
                    check_field("distinct_count", want.distinct_count, got.distinct_count);
                    check_field("message_done", want.message_done, got.message_done);
                end
            end
            if (req_bus.valid && req_bus.ready)
                expected_words.push_back(next_freq_word(t_cmd'(req_bus.command), req_bus.symbol,
                                                        req_bus.slot_index,
                                                        req_bus.last_symbol));
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned target;
        int unsigned m;
        i_rst_n             = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.command     = CMD_COUNT;
        req_bus.symbol      = '0;
        req_bus.slot_index  = '0;
        req_bus.last_symbol = 1'b0;
        res_bus.ready       = 1'b0;
        foreach (seen_sym[k]) seen_sym[k] = 1'b0;
        used_slots = '0;

        // empty reads, spare code, first/repeat counts, clear and recount
        add_req(CMD_READ, 8'h00, 8'h00, 0);
        add_req(CMD_READ, 8'hFF, 8'hFF, 1);
        add_req(CMD_SPARE, 8'hFF, 8'hFF, 1);
        add_req(CMD_COUNT, 8'h00, 8'hFF, 0);
        add_req(CMD_COUNT, 8'hFF, 8'h00, 0);
        add_req(CMD_COUNT, 8'h00, 8'h00, 0);
        add_req(CMD_COUNT, 8'hAA, 8'h55, 0);
        add_req(CMD_COUNT, 8'h55, 8'hAA, 1);
        add_req(CMD_READ, 8'h00, 8'h00, 0);
        add_req(CMD_READ, 8'h00, 8'h01, 0);
        add_req(CMD_READ, 8'h00, 8'h03, 1);
        add_req(CMD_READ, 8'h00, 8'h04, 0);
        add_req(CMD_READ, 8'h00, 8'hFF, 0);
        add_req(CMD_SPARE, 8'h00, 8'h00, 0);
        add_req(CMD_CLEAR, 8'hFF, 8'hFF, 1);
        add_req(CMD_READ, 8'h00, 8'h00, 0);
        add_req(CMD_SPARE, 8'h12, 8'h34, 0);
        add_req(CMD_COUNT, 8'hFF, 8'h00, 0);
        add_req(CMD_COUNT, 8'hFF, 8'h00, 1);
        add_req(CMD_READ, 8'h00, 8'h00, 0);

        // sender waits for the table to drain before random messages
        add_req(CMD_READ, $urandom, $urandom, $urandom, 1'b1);
        target = feed_q.size() + 900;
        m = 0;
        while (feed_q.size() < target) begin
            if (m == 4)
                queue_full_set();
            else if ($urandom_range(0, 3) == 0)
                queue_message($urandom_range(1, 8), $urandom_range(1, 4));
            else
                queue_message($urandom_range(4, 60),
                              ($urandom_range(0, 2) == 0) ? NSYM : $urandom_range(2, 24));
            m++;
        end

        // repeated symbol, back to back
        add_req(CMD_CLEAR, 0, 0, 0, 1'b1, 1'b1);
        repeat (BURST_LEN) add_req(CMD_COUNT, 8'hC3, $urandom, 0, 1'b0, 1'b1);
        add_req(CMD_READ, 0, 0, 0, 1'b0, 1'b1);
        add_req(CMD_READ, 0, 1, 0, 1'b0, 1'b1);
        add_req(CMD_COUNT, 8'hC3, 0, 1, 1'b0, 1'b1);
        total_words = feed_q.size();

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (results_taken >= total_words);
        repeat (TAIL) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: symbol_frequency_table.f
hw/rtl/sft_pkg.sv
hw/rtl/sft_if.sv
hw/rtl/symbol_frequency_table.sv
tb/sv/tb_top.sv
